// File: rtl/core/bdrh_pkg.sv
// ----------------------------------------------------------------------------
// Digit rotate hash package
// Port widths and default parameter values shared by the hash core.
// ----------------------------------------------------------------------------
package bdrh_pkg;

    localparam int LIMB_PORT_W = 64;
    localparam int COUNT_W     = 11;
    localparam int HASH_W      = 64;

    localparam int DIGIT_BITS_DEF = 30;
    localparam int LIMB_BITS_DEF  = 64;
    localparam int MAX_LIMBS_DEF  = 1024;

endpackage

// File: rtl/core/bignum_digit_rotate_hash_top.sv
// ----------------------------------------------------------------------------
// Big number digit rotate hash
// Folds the limbs of an unsigned big number into a 64-bit rotate-add hash.
// ----------------------------------------------------------------------------
// The block takes one limb per clock, most significant limb first, and
// sustains one transaction per cycle on the input channel while the result
// register can take each finished hash. A limb is held in an input register.
// From that register every whole digit it completes is folded into the
// running hash, and the result register, which drives m_hash, captures the
// hash on the limb marked last. The per-cycle work is a chain of at most
// (DIGIT_BITS - 1 + LIMB_BITS) / DIGIT_BITS rotate-add steps, which is three
// at the default digit width. The padding of the top digit is taken from two
// small constant tables when the first limb is accepted. A first limb with a
// count of zero gives a hash of zero.
module bignum_digit_rotate_hash_top #(
    parameter int DIGIT_BITS = bdrh_pkg::DIGIT_BITS_DEF,
    parameter int LIMB_BITS  = bdrh_pkg::LIMB_BITS_DEF,
    parameter int MAX_LIMBS  = bdrh_pkg::MAX_LIMBS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [bdrh_pkg::LIMB_PORT_W-1:0]       s_limb,
    input  logic [bdrh_pkg::COUNT_W-1:0]           s_limb_count,
    input  logic                                   s_first,
    input  logic                                   s_last,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bdrh_pkg::HASH_W-1:0]     m_hash
);
    import bdrh_pkg::*;

    localparam int OW    = $clog2(DIGIT_BITS);
    localparam int CW    = DIGIT_BITS - 1;
    localparam int WMAX  = CW + LIMB_BITS;
    localparam int TW    = $clog2(WMAX + 1);
    localparam int NSTEP = WMAX / DIGIT_BITS;
    localparam int LO_W  = 6;
    localparam int HI_W  = COUNT_W - LO_W;

    localparam logic [COUNT_W-1:0] CNT_MAX =
        (MAX_LIMBS > (2 ** COUNT_W) - 1) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_LIMBS);

    logic [OW-1:0] tab_hi [2**HI_W];
    logic [OW-1:0] tab_lo [2**LO_W];

    for (genvar gi = 0; gi < 2 ** HI_W; gi++) begin : g_tab_hi
        localparam logic [OW-1:0] HV = OW'((gi * (2 ** LO_W) * LIMB_BITS) % DIGIT_BITS);
        assign tab_hi[gi] = HV;
    end

    for (genvar gj = 0; gj < 2 ** LO_W; gj++) begin : g_tab_lo
        localparam logic [OW-1:0] LV = OW'((gj * LIMB_BITS) % DIGIT_BITS);
        assign tab_lo[gj] = LV;
    end

    // Input stage.
    logic                 s1_valid_reg, s1_valid_next;
    logic [LIMB_BITS-1:0] s1_limb_reg,  s1_limb_next;
    logic [OW-1:0]        s1_pad_reg,   s1_pad_next;
    logic                 s1_first_reg, s1_first_next;
    logic                 s1_last_reg,  s1_last_next;
    logic                 s1_zero_reg,  s1_zero_next;

    // Hash state.
    logic [HASH_W-1:0]    acc_reg,   acc_next;
    logic [CW-1:0]        carry_reg, carry_next;
    logic [OW-1:0]        off_reg,   off_next;
    logic                 busy_reg,  busy_next;

    // Result register.
    logic                 m_valid_reg, m_valid_next;
    logic [HASH_W-1:0]    m_hash_reg,  m_hash_next;

    logic [COUNT_W-1:0]   cnt_clamp;
    logic [OW:0]          pad_sum;
    logic [OW:0]          pad_mod;

    logic [OW-1:0]        r_in;
    logic [WMAX-1:0]      word;
    logic [WMAX-1:0]      aligned;
    logic [TW-1:0]        total;
    logic [TW-1:0]        rem;
    logic [HASH_W-1:0]    acc_fold;
    logic [CW-1:0]        carry_fold;

    logic                 produces;
    logic                 out_free;
    logic                 adv;

    always_comb begin
        cnt_clamp = (s_limb_count > CNT_MAX) ? CNT_MAX : s_limb_count;
        pad_sum   = {1'b0, tab_hi[cnt_clamp[COUNT_W-1:LO_W]]}
                  + {1'b0, tab_lo[cnt_clamp[LO_W-1:0]]};
        pad_mod   = (pad_sum >= (OW+1)'(DIGIT_BITS)) ?
                    pad_sum - (OW+1)'(DIGIT_BITS) : pad_sum;
    end

    always_comb begin
        r_in    = s1_first_reg ? s1_pad_reg : off_reg;
        word    = {(s1_first_reg ? {CW{1'b0}} : carry_reg), s1_limb_reg};
        total   = TW'(r_in) + TW'(LIMB_BITS);
        aligned = word << (OW'(DIGIT_BITS - 1) - r_in);
        acc_fold = s1_first_reg ? {HASH_W{1'b0}} : acc_reg;
        rem      = total;
        for (int k = 0; k < NSTEP; k++) begin
            if (TW'((k + 1) * DIGIT_BITS) <= total) begin
                acc_fold = {acc_fold[HASH_W-1-DIGIT_BITS:0],
                            acc_fold[HASH_W-1:HASH_W-DIGIT_BITS]}
                         + HASH_W'(aligned[WMAX-1-k*DIGIT_BITS -: DIGIT_BITS]);
                rem = rem - TW'(DIGIT_BITS);
            end
        end
        for (int i = 0; i < CW; i++) begin
            carry_fold[i] = word[i] & (TW'(i) < rem);
        end
    end

    always_comb begin
        produces = s1_first_reg ? (s1_zero_reg | s1_last_reg) : (busy_reg & s1_last_reg);
        out_free = ~m_valid_reg | m_ready;
        adv      = s1_valid_reg & (~produces | out_free);
        s_ready  = ~s1_valid_reg | adv;

        s1_valid_next = s1_valid_reg;
        s1_limb_next  = s1_limb_reg;
        s1_pad_next   = s1_pad_reg;
        s1_first_next = s1_first_reg;
        s1_last_next  = s1_last_reg;
        s1_zero_next  = s1_zero_reg;
        if (s_ready) begin
            s1_valid_next = s_valid;
            s1_limb_next  = s_limb[LIMB_BITS-1:0];
            s1_pad_next   = (pad_mod == '0) ? '0 : OW'(DIGIT_BITS) - pad_mod[OW-1:0];
            s1_first_next = s_first;
            s1_last_next  = s_last;
            s1_zero_next  = (s_limb_count == '0);
        end

        acc_next     = acc_reg;
        carry_next   = carry_reg;
        off_next     = off_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_hash_next  = m_hash_reg;
        if (adv) begin
            if (s1_first_reg && s1_zero_reg) begin
                acc_next     = '0;
                carry_next   = '0;
                off_next     = '0;
                busy_next    = 1'b0;
                m_valid_next = 1'b1;
                m_hash_next  = '0;
            end else if (s1_first_reg || busy_reg) begin
                acc_next = acc_fold;
                if (s1_last_reg) begin
                    carry_next   = '0;
                    off_next     = '0;
                    busy_next    = 1'b0;
                    m_valid_next = 1'b1;
                    m_hash_next  = acc_fold;
                end else begin
                    carry_next = carry_fold;
                    off_next   = OW'(rem);
                    busy_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            carry_reg    <= '0;
            off_reg      <= '0;
            busy_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            acc_reg      <= acc_next;
            carry_reg    <= carry_next;
            off_reg      <= off_next;
            busy_reg     <= busy_next;
            m_valid_reg  <= m_valid_next;
        end
        s1_limb_reg  <= s1_limb_next;
        s1_pad_reg   <= s1_pad_next;
        s1_first_reg <= s1_first_next;
        s1_last_reg  <= s1_last_next;
        s1_zero_reg  <= s1_zero_next;
        m_hash_reg   <= m_hash_next;
    end

    assign m_valid = m_valid_reg;
    assign m_hash  = $signed(m_hash_reg);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Digit rotate hash testbench
// Streams big numbers limb by limb into the hash core and checks every hash
// against a cycle-free model of the digit split, padding and rotate-add fold.
// ----------------------------------------------------------------------------
module tb_top;
    import bdrh_pkg::*;

    localparam int DIGIT_W     = DIGIT_BITS_DEF;
    localparam int LIMB_W      = LIMB_BITS_DEF;
    localparam int LIMB_CAP    = MAX_LIMBS_DEF;
    localparam int SEND_ITEMS  = 1200;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 40;

    typedef struct packed {
        logic [LIMB_PORT_W-1:0] limb;
        logic [COUNT_W-1:0]     count;
        logic                   first;
        logic                   last;
    } limb_item_t;

    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic [LIMB_PORT_W-1:0]        s_limb       = '0;
    logic [COUNT_W-1:0]            s_limb_count = '0;
    logic                          s_first      = 1'b0;
    logic                          s_last       = 1'b0;
    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic signed [HASH_W-1:0]      m_hash;

    limb_item_t                    limb_queue[$];
    logic signed [HASH_W-1:0]      hash_expect[$];
    limb_item_t                    on_bus;

    logic [63:0]                   acc_q;
    logic [63:0]                   pend_bits;
    int unsigned                   pend_len;
    bit                            in_number;

    int unsigned                   send_gap    = 0;
    bit                            send_burst  = 1'b0;
    int unsigned                   recv_wait   = 0;
    bit                            recv_burst  = 1'b0;
    bit                            hold_done   = 1'b0;
    int unsigned                   hashes_seen = 0;
    int unsigned                   err_count   = 0;
    int unsigned                   idle_cycles = 0;

    bignum_digit_rotate_hash_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_limb       (s_limb),
        .s_limb_count (s_limb_count),
        .s_first      (s_first),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash       (m_hash)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [63:0] ones(int unsigned n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic logic [63:0] rand_limb();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void push_item(logic [63:0] limb, int unsigned cnt, bit f, bit l);
        limb_item_t it;
        it.limb  = limb;
        it.count = cnt[COUNT_W-1:0];
        it.first = f;
        it.last  = l;
        limb_queue.push_back(it);
    endfunction

    // The count field of a limb that does not start a number is never read,
    // so it carries random bits there.
    function automatic void queue_number(int unsigned cnt, int unsigned n, bit close);
        for (int unsigned i = 0; i < n; i++) begin
            push_item(rand_limb(), (i == 0) ? cnt : $urandom_range(0, 2047),
                      i == 0, close && (i == n - 1));
        end
    endfunction

    task automatic predict_hash(input limb_item_t it);
        int unsigned n;
        int unsigned pos;
        int unsigned need;
        logic [63:0] limb_v;
        logic [63:0] part;
        if (it.first) begin
            n = it.count;
            if (n == 0) begin
                in_number = 1'b0;
                acc_q     = '0;
                pend_bits = '0;
                pend_len  = 0;
                hash_expect.push_back('0);
                return;
            end
            if (n > LIMB_CAP) begin
                n = LIMB_CAP;
            end
            acc_q     = '0;
            pend_bits = '0;
            pend_len  = (DIGIT_W - (n * LIMB_W) % DIGIT_W) % DIGIT_W;
            in_number = 1'b1;
        end else if (!in_number) begin
            return;
        end

        // Whole digits are cut from the top of the limb, the first one
        // completed by the bits left over from the previous limb.
        pos    = LIMB_W;
        limb_v = it.limb & ones(LIMB_W);
        while (pend_len + pos >= DIGIT_W) begin
            need      = DIGIT_W - pend_len;
            part      = (pend_bits << need) | ((limb_v >> (pos - need)) & ones(need));
            acc_q     = {acc_q[63-DIGIT_W:0], acc_q[63:64-DIGIT_W]} + part;
            pos       = pos - need;
            pend_len  = 0;
            pend_bits = '0;
        end
        pend_bits = (pend_bits << pos) | (limb_v & ones(pos));
        pend_len  = pend_len + pos;

        if (it.last) begin
            hash_expect.push_back(acc_q);
            in_number = 1'b0;
            pend_bits = '0;
            pend_len  = 0;
        end
    endtask

    always @(posedge aclk) begin : drive_proc
        limb_item_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_hash(on_bus);
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (limb_queue.size() != 0) begin
                    nxt           = limb_queue.pop_front();
                    on_bus       <= nxt;
                    s_valid      <= 1'b1;
                    s_limb       <= nxt.limb;
                    s_limb_count <= nxt.count;
                    s_first      <= nxt.first;
                    s_last       <= nxt.last;
                    send_gap     <= send_burst ? 0 : $urandom_range(0, 7);
                    if ($urandom_range(0, 63) == 0) begin
                        send_burst <= !send_burst;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off lets the core back up until it stalls its input.
    always @(posedge aclk) begin : recv_proc
        int unsigned w;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else if (m_valid && m_ready) begin
            w = recv_burst ? 0 : $urandom_range(0, 7);
            if (!hold_done && hashes_seen == HOLD_AT) begin
                w = HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            if ($urandom_range(0, 31) == 0) begin
                recv_burst <= !recv_burst;
            end
            recv_wait <= w;
            m_ready   <= (w == 0);
        end else if (!m_ready) begin
            if (recv_wait > 1) begin
                recv_wait <= recv_wait - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_proc
        logic signed [HASH_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            hashes_seen <= hashes_seen + 1;
            if (hash_expect.size() == 0) begin
                $display("%0t: hash with no transaction pending, expected none, got %h",
                         $time, m_hash);
                err_count <= err_count + 1;
            end else begin
                want = hash_expect.pop_front();
                if (m_hash !== want) begin
                    $display("%0t: hash mismatch, expected %h, got %h", $time, want, m_hash);
                    err_count <= err_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stim_proc
        int unsigned pick;
        int unsigned n;
        acc_q     = '0;
        pend_bits = '0;
        pend_len  = 0;
        in_number = 1'b0;

        push_item(rand_limb(), 0, 1'b1, 1'b0);
        push_item('1, 0, 1'b1, 1'b1);
        push_item('1, 1, 1'b1, 1'b1);
        push_item('0, 1, 1'b1, 1'b1);
        push_item(64'h8000_0000_0000_0000, 2, 1'b1, 1'b0);
        push_item(64'h0000_0000_0000_0001, 2, 1'b0, 1'b1);
        push_item('1, 5, 1'b0, 1'b1);
        push_item(64'h0123_4567_89ab_cdef, 3, 1'b0, 1'b0);
        push_item('1, 3, 1'b1, 1'b0);
        push_item('1, 3, 1'b0, 1'b0);
        push_item(64'hdead_beef_0000_ffff, 1, 1'b1, 1'b1);
        push_item('1, 2047, 1'b1, 1'b1);
        push_item('1, 1025, 1'b1, 1'b0);
        push_item('1, 0, 1'b0, 1'b1);
        push_item(64'h5555_5555_5555_5555, 1, 1'b1, 1'b0);
        push_item(64'haaaa_aaaa_aaaa_aaaa, 0, 1'b0, 1'b0);
        push_item(64'hffff_0000_ffff_0000, 0, 1'b0, 1'b1);
        push_item('1, LIMB_CAP, 1'b1, 1'b1);
        push_item('1, 15, 1'b1, 1'b1);
        push_item(64'h7fff_ffff_ffff_ffff, 4, 1'b1, 1'b0);
        push_item(64'h8000_0000_0000_0001, 4, 1'b0, 1'b0);
        push_item('1, 4, 1'b0, 1'b0);
        push_item('0, 4, 1'b0, 1'b1);

        while (limb_queue.size() < SEND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
                queue_number(n, n, 1'b1);
            end else if (pick < 88) begin
                n = $urandom_range(1, 6);
                queue_number($urandom_range(0, 2047), n, 1'b1);
            end else if (pick < 94) begin
                n = $urandom_range(1, 4);
                queue_number(n + $urandom_range(0, 3), n, 1'b0);
            end else begin
                push_item(rand_limb(), $urandom_range(0, 2047),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (limb_queue.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (hash_expect.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/bdrh_pkg.sv
rtl/core/bignum_digit_rotate_hash_top.sv
tb/tb_top.sv
